### hdl/rsi_pkg.sv
`default_nettype none

package rsi_pkg;

    // Per-coordinate side information carried alongside a quotient
    typedef struct packed {
        logic hit;   // ray meets the segment
        logic ovf;   // quotient magnitude beyond the quotient width
        logic neg;   // quotient sign (sign of the direction component)
    } t_rsi_flags;

endpackage

`default_nettype wire

### hdl/ray_segment_intersect_2d.sv
`default_nettype none

// Ray / line segment intersection in 2D, signed fixed point coordinates.
//
// Usage: drive the eight coordinate inputs and pulse start. A word is taken
// at every rising edge with start high and busy low; busy is always low, so
// a new word may be issued every cycle.
// Each word produces exactly one result word, shown on the o_ ports for one
// cycle with o_valid high. The receiver cannot stall; results must be taken
// when o_valid is high.
// Pipeline: 7 front stages, COORD_WIDTH+1 divider stages and one output
// register. Throughput: one word per cycle. The depth is set by the
// restoring divider, which resolves one quotient bit per stage.
// On a miss o_hit, o_hit_x, o_hit_y and o_saturated are all zero.
// o_saturated flags a coordinate clamped to the signed range.
// Reset (synchronous, active low) drops every word in flight; no result
// appears for words accepted before reset was released.
module ray_segment_intersect_2d #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_ray_origin_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_ray_origin_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_ray_dir_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_ray_dir_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_seg_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_seg_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_seg_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_seg_end_y,
    output logic                               o_valid,
    output logic                               o_hit,
    output logic signed [COORD_WIDTH-1:0]      o_hit_x,
    output logic signed [COORD_WIDTH-1:0]      o_hit_y,
    output logic                               o_saturated
);
    import rsi_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int PW  = 2 * W + 2;     // product width
    localparam int SW  = 2 * W + 3;     // determinant / numerator width, signed
    localparam int MW  = 2 * W + 2;     // magnitude of det and t numerator
    localparam int NL  = MW / 2;        // low slice of t numerator
    localparam int NH  = MW - NL;       // high slice
    localparam int QW  = W + 1;         // quotient bits kept
    localparam int RW  = MW + QW;       // dividend width
    localparam int LAT = QW + 8;
    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

    assign busy = 1'b0;

    // Valid bits for the front stages
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;

    // Stage 1: edge differences
    logic signed [W-1:0] r1_ox, r1_oy, r1_dx, r1_dy;
    logic signed [W:0]   r1_xx, r1_xy, r1_zx, r1_zy;

    // Stage 2: six products
    logic signed [W-1:0]  r2_ox, r2_oy, r2_dx, r2_dy;
    logic signed [PW-1:0] r2_p1, r2_p2, r2_p3, r2_p4, r2_p5, r2_p6;

    // Stage 3: Cramer's determinants
    logic signed [W-1:0]  r3_ox, r3_oy, r3_dx, r3_dy;
    logic signed [SW-1:0] r3_det, r3_nu, r3_nt;

    // Stage 4: sign normalization and hit test
    logic signed [W-1:0] r4_ox, r4_oy;
    logic [W-1:0]        r4_adx, r4_ady;
    logic                r4_nx, r4_ny, r4_hit;
    logic [MW-1:0]       r4_detm, r4_ntm;
    logic signed [SW-1:0] n_det, n_nu, n_nt;
    logic                n_hit;

    // Stage 5: partial products of t numerator times direction
    logic signed [W-1:0] r5_ox, r5_oy;
    logic                r5_nx, r5_ny, r5_hit;
    logic [MW-1:0]       r5_detm;
    logic [NL+W-1:0]     r5_plx, r5_ply;
    logic [NH+W-1:0]     r5_phx, r5_phy;

    // Stage 6: dividends
    logic signed [W-1:0] r6_ox, r6_oy;
    logic                r6_nx, r6_ny, r6_hit;
    logic [MW-1:0]       r6_detm;
    logic [RW-1:0]       r6_numx, r6_numy;

    // Stage 7: quotient range check
    logic signed [W-1:0] r7_ox, r7_oy;
    logic                r7_nx, r7_ny, r7_hit, r7_ovfx, r7_ovfy;
    logic [MW-1:0]       r7_detm;
    logic [RW-1:0]       r7_numx, r7_numy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // Flip everything so the determinant is positive, then test
    // u in [0,1] and t >= 0 against it.
    always_comb begin
        n_det = r3_det[SW-1] ? -r3_det : r3_det;
        n_nu  = r3_det[SW-1] ? -r3_nu  : r3_nu;
        n_nt  = r3_det[SW-1] ? -r3_nt  : r3_nt;
        n_hit = (r3_det != '0) && !n_nu[SW-1] && (n_nu <= n_det) && !n_nt[SW-1];
    end

    always_ff @(posedge i_clk) begin
        // stage 1
        r1_ox <= i_ray_origin_x;
        r1_oy <= i_ray_origin_y;
        r1_dx <= i_ray_dir_x;
        r1_dy <= i_ray_dir_y;
        r1_xx <= (W+1)'(i_seg_start_x) - (W+1)'(i_seg_end_x);
        r1_xy <= (W+1)'(i_seg_start_y) - (W+1)'(i_seg_end_y);
        r1_zx <= (W+1)'(i_seg_start_x) - (W+1)'(i_ray_origin_x);
        r1_zy <= (W+1)'(i_seg_start_y) - (W+1)'(i_ray_origin_y);
        // stage 2
        r2_ox <= r1_ox;
        r2_oy <= r1_oy;
        r2_dx <= r1_dx;
        r2_dy <= r1_dy;
        r2_p1 <= r1_xx * r1_dy;
        r2_p2 <= r1_dx * r1_xy;
        r2_p3 <= r1_zx * r1_dy;
        r2_p4 <= r1_dx * r1_zy;
        r2_p5 <= r1_xx * r1_zy;
        r2_p6 <= r1_zx * r1_xy;
        // stage 3
        r3_ox  <= r2_ox;
        r3_oy  <= r2_oy;
        r3_dx  <= r2_dx;
        r3_dy  <= r2_dy;
        r3_det <= SW'(r2_p1) - SW'(r2_p2);
        r3_nu  <= SW'(r2_p3) - SW'(r2_p4);
        r3_nt  <= SW'(r2_p5) - SW'(r2_p6);
        // stage 4
        r4_ox   <= r3_ox;
        r4_oy   <= r3_oy;
        r4_nx   <= r3_dx[W-1];
        r4_ny   <= r3_dy[W-1];
        r4_adx  <= r3_dx[W-1] ? W'(-r3_dx) : r3_dx;
        r4_ady  <= r3_dy[W-1] ? W'(-r3_dy) : r3_dy;
        r4_hit  <= n_hit;
        r4_detm <= n_det[MW-1:0];
        r4_ntm  <= n_nt[MW-1:0];
        // stage 5
        r5_ox   <= r4_ox;
        r5_oy   <= r4_oy;
        r5_nx   <= r4_nx;
        r5_ny   <= r4_ny;
        r5_hit  <= r4_hit;
        r5_detm <= r4_detm;
        r5_plx  <= r4_ntm[NL-1:0] * r4_adx;
        r5_phx  <= r4_ntm[MW-1:NL] * r4_adx;
        r5_ply  <= r4_ntm[NL-1:0] * r4_ady;
        r5_phy  <= r4_ntm[MW-1:NL] * r4_ady;
        // stage 6
        r6_ox   <= r5_ox;
        r6_oy   <= r5_oy;
        r6_nx   <= r5_nx;
        r6_ny   <= r5_ny;
        r6_hit  <= r5_hit;
        r6_detm <= r5_detm;
        r6_numx <= (RW'(r5_phx) << NL) + RW'(r5_plx);
        r6_numy <= (RW'(r5_phy) << NL) + RW'(r5_ply);
        // stage 7: a quotient past QW bits saturates for any origin
        r7_ox   <= r6_ox;
        r7_oy   <= r6_oy;
        r7_nx   <= r6_nx;
        r7_ny   <= r6_ny;
        r7_hit  <= r6_hit;
        r7_detm <= r6_detm;
        r7_numx <= r6_numx;
        r7_numy <= r6_numy;
        r7_ovfx <= r6_numx >= (RW'(r6_detm) << QW);
        r7_ovfy <= r6_numy >= (RW'(r6_detm) << QW);
    end

    t_rsi_flags     fx_in, fy_in, fx_out, fy_out;
    logic           vx, vy;
    logic [QW-1:0]  qx, qy;
    logic [W-1:0]   bx, by;

    assign fx_in = '{hit: r7_hit, ovf: r7_ovfx, neg: r7_nx};
    assign fy_in = '{hit: r7_hit, ovf: r7_ovfy, neg: r7_ny};

    rsi_div #(.DENW(MW), .QW(QW), .BASEW(W)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v7),
        .i_num   (r7_numx),
        .i_den   (r7_detm),
        .i_base  (r7_ox),
        .i_flags (fx_in),
        .o_valid (vx),
        .o_quo   (qx),
        .o_base  (bx),
        .o_flags (fx_out)
    );

    rsi_div #(.DENW(MW), .QW(QW), .BASEW(W)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v7),
        .i_num   (r7_numy),
        .i_den   (r7_detm),
        .i_base  (r7_oy),
        .i_flags (fy_in),
        .o_valid (vy),
        .o_quo   (qy),
        .o_base  (by),
        .o_flags (fy_out)
    );

    // Origin plus signed quotient, clamped; returns {saturated, coordinate}
    function automatic logic [W:0] f_place(input logic [W-1:0] base,
                                           input logic [QW-1:0] quo,
                                           input t_rsi_flags flg);
        logic signed [W+1:0] sq;
        logic signed [W+2:0] sum;
        sq  = flg.neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        sum = (W+3)'($signed(base)) + (W+3)'(sq);
        if (flg.ovf) begin
            return {1'b1, (flg.neg ? CMIN : CMAX)};
        end else if (sum > (W+3)'(CMAX)) begin
            return {1'b1, CMAX};
        end else if (sum < (W+3)'(CMIN)) begin
            return {1'b1, CMIN};
        end
        return {1'b0, sum[W-1:0]};
    endfunction

    logic [W:0] px, py;
    assign px = f_place(bx, qx, fx_out);
    assign py = f_place(by, qy, fy_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= vx;
        end
    end

    // Zero the payload on a miss
    always_ff @(posedge i_clk) begin
        o_hit       <= fx_out.hit;
        o_hit_x     <= fx_out.hit ? px[W-1:0] : '0;
        o_hit_y     <= fx_out.hit ? py[W-1:0] : '0;
        o_saturated <= fx_out.hit && (px[W] || py[W]);
    end

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vx == vy)
        else $error("x and y divider lanes out of step");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result missing after pipeline latency");

    a_sat_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> o_hit)
        else $error("saturation flagged on a miss");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_hit_x == '0 && o_hit_y == '0))
        else $error("miss carries a nonzero point");

endmodule

`default_nettype wire

### hdl/rsi_div.sv
`default_nettype none

module rsi_div #(
    parameter int DENW  = 66,
    parameter int QW    = 33,
    parameter int BASEW = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [DENW+QW-1:0]        i_num,
    input  wire logic [DENW-1:0]           i_den,
    input  wire logic [BASEW-1:0]          i_base,
    input  wire rsi_pkg::t_rsi_flags       i_flags,
    output logic                           o_valid,
    output logic [QW-1:0]                  o_quo,
    output logic [BASEW-1:0]               o_base,
    output rsi_pkg::t_rsi_flags            o_flags
);
    import rsi_pkg::*;

    localparam int RW = DENW + QW;

    // Restoring division, one quotient bit per stage, MSB first. Callers
    // must keep i_num < i_den << QW for a meaningful quotient; unchecked.
    logic            a_v    [0:QW];
    logic [RW-1:0]   a_rem  [0:QW];
    logic [QW-1:0]   a_quo  [0:QW];
    logic [DENW-1:0] a_den  [0:QW];
    logic [BASEW-1:0] a_base [0:QW];
    t_rsi_flags      a_flg  [0:QW];

    assign a_v[0]    = i_valid;
    assign a_rem[0]  = i_num;
    assign a_quo[0]  = '0;
    assign a_den[0]  = i_den;
    assign a_base[0] = i_base;
    assign a_flg[0]  = i_flags;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic             r_v;
        logic [RW-1:0]    r_rem;
        logic [QW-1:0]    r_quo;
        logic [DENW-1:0]  r_den;
        logic [BASEW-1:0] r_base;
        t_rsi_flags       r_flg;
        logic [RW-1:0]    sh;
        logic             ge;
        logic [RW-1:0]    n_rem;
        logic [QW-1:0]    n_quo;

        assign sh = RW'(a_den[k]) << B;
        assign ge = (a_rem[k] >= sh);

        always_comb begin
            n_quo    = a_quo[k];
            n_quo[B] = ge;
            n_rem    = ge ? (a_rem[k] - sh) : a_rem[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= a_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_den  <= a_den[k];
            r_base <= a_base[k];
            r_flg  <= a_flg[k];
        end

        assign a_v[k+1]    = r_v;
        assign a_rem[k+1]  = r_rem;
        assign a_quo[k+1]  = r_quo;
        assign a_den[k+1]  = r_den;
        assign a_base[k+1] = r_base;
        assign a_flg[k+1]  = r_flg;
    end

    assign o_valid = a_v[QW];
    assign o_quo   = a_quo[QW];
    assign o_base  = a_base[QW];
    assign o_flags = a_flg[QW];

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CW        = 32;
    localparam int N_RANDOM  = 1400;
    localparam int IDLE_MAX  = 4000;   // cycles with no word moving on either side
    localparam int DRAIN     = CW + 20; // block latency plus margin

    localparam logic signed [CW-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CW-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [CW-1:0] ONE   = 32'sh0001_0000;  // 1.0 in Q16.16

    typedef struct {
        logic signed [CW-1:0] ox, oy, dx, dy, sx, sy, ex, ey;
    } t_ray_seg;

    typedef struct {
        logic                 hit;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 sat;
    } t_point;

    typedef struct {
        t_ray_seg rs;
        bit       typed;  // expectation written in the table
        t_point   want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_ray_seg drv = '{default: '0};
    t_stim_row cur_row;
    logic o_valid, o_hit, o_saturated;
    logic signed [CW-1:0] o_hit_x, o_hit_y;

    t_point expected_points[$];
    t_stim_row directed_rows[$];
    int n_fail = 0;
    int n_words_in = 0;
    int n_hits_seen = 0;
    int n_miss_seen = 0;
    int idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    ray_segment_intersect_2d #(.COORD_WIDTH(CW)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_ray_origin_x (drv.ox),
        .i_ray_origin_y (drv.oy),
        .i_ray_dir_x    (drv.dx),
        .i_ray_dir_y    (drv.dy),
        .i_seg_start_x  (drv.sx),
        .i_seg_start_y  (drv.sy),
        .i_seg_end_x    (drv.ex),
        .i_seg_end_y    (drv.ey),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_hit_x        (o_hit_x),
        .o_hit_y        (o_hit_y),
        .o_saturated    (o_saturated)
    );

    // Solve the 2x2 system exactly in wide signed integers. 160 bits hold
    // the largest product, numerator (67 bits) times direction (32 bits).
    function automatic t_point intersect_point(t_ray_seg r);
        logic signed [159:0] ox, oy, dx, dy, xx, xy, zx, zy, det, nu, nt, px, py;
        t_point p;
        ox = r.ox; oy = r.oy; dx = r.dx; dy = r.dy;
        xx = r.sx; xx = xx - r.ex;
        xy = r.sy; xy = xy - r.ey;
        zx = r.sx; zx = zx - ox;
        zy = r.sy; zy = zy - oy;
        p = '{hit: 1'b0, x: '0, y: '0, sat: 1'b0};
        det = xx * dy - dx * xy;
        if (det == 0)
            return p;
        nu = zx * dy - dx * zy;
        nt = xx * zy - zx * xy;
        // fold the sign into the numerators so the range test is one-sided
        if (det < 0) begin
            det = -det;
            nu = -nu;
            nt = -nt;
        end
        if (nu < 0 || nu > det || nt < 0)
            return p;
        // SV signed division truncates toward zero, as the block does
        px = ox + (nt * dx) / det;
        py = oy + (nt * dy) / det;
        p.hit = 1'b1;
        if (px > C_MAX) begin p.x = C_MAX; p.sat = 1'b1; end
        else if (px < C_MIN) begin p.x = C_MIN; p.sat = 1'b1; end
        else p.x = px[CW-1:0];
        if (py > C_MAX) begin p.y = C_MAX; p.sat = 1'b1; end
        else if (py < C_MIN) begin p.y = C_MIN; p.sat = 1'b1; end
        else p.y = py[CW-1:0];
        return p;
    endfunction

    // Record the expectation of every word at the edge that takes it.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            expected_points.push_back(cur_row.typed ? cur_row.want
                                                    : intersect_point(cur_row.rs));
            n_words_in++;
        end
    end

    // Compare each result strobe against the oldest expectation.
    always @(posedge i_clk) begin
        t_point w;
        if (i_rst_n && o_valid) begin
            if (expected_points.size() == 0) begin
                $error("result with nothing expected: hit=%0b x=%0d y=%0d",
                       o_hit, o_hit_x, o_hit_y);
                n_fail++;
            end else begin
                w = expected_points.pop_front();
                if (o_hit !== w.hit) begin
                    $error("hit: expected %0b, got %0b", w.hit, o_hit);
                    n_fail++;
                end
                if (o_hit_x !== w.x) begin
                    $error("hit_x: expected %0d, got %0d", w.x, o_hit_x);
                    n_fail++;
                end
                if (o_hit_y !== w.y) begin
                    $error("hit_y: expected %0d, got %0d", w.y, o_hit_y);
                    n_fail++;
                end
                if (o_saturated !== w.sat) begin
                    $error("saturated: expected %0b, got %0b", w.sat, o_saturated);
                    n_fail++;
                end
                if (w.hit) n_hits_seen++;
                else n_miss_seen++;
            end
        end
    end

    // Watchdog: end the run when no word moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("watchdog: no traffic for %0d cycles", IDLE_MAX);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] rand_full();
        return $urandom();
    endfunction

    // signed value in [-2^28, 2^28]
    function automatic logic signed [CW-1:0] rand_mid();
        return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Hold start low for the gap, then present the word and hold it until taken.
    task automatic send_word(t_stim_row row, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        drv <= row.rs;
        cur_row <= row;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic t_stim_row mk(t_ray_seg rs);
        t_stim_row row;
        row.rs = rs;
        row.typed = 1'b0;
        row.want = '{hit: 1'b0, x: '0, y: '0, sat: 1'b0};
        return row;
    endfunction

    function automatic t_stim_row mk_typed(t_ray_seg rs, logic h,
                                           logic signed [CW-1:0] x,
                                           logic signed [CW-1:0] y);
        t_stim_row row;
        row = mk(rs);
        row.typed = 1'b1;
        row.want = '{hit: h, x: x, y: y, sat: 1'b0};
        return row;
    endfunction

    // Build a ray aimed at a point on a random segment; content stays mid range.
    function automatic t_ray_seg aimed_ray();
        t_ray_seg r;
        logic signed [CW-1:0] px, py;
        int k;
        r.sx = rand_mid(); r.sy = rand_mid();
        r.ex = rand_mid(); r.ey = rand_mid();
        k = $urandom_range(0, 8);
        px = r.sx + (r.ex - r.sx) / 8 * k;
        py = r.sy + (r.ey - r.sy) / 8 * k;
        r.ox = rand_mid(); r.oy = rand_mid();
        r.dx = px - r.ox;
        r.dy = py - r.oy;
        // scale the direction components down now and then, by separate shifts
        if ($urandom_range(0, 3) == 0) begin
            r.dx = r.dx >>> $urandom_range(1, 12);
            r.dy = r.dy >>> $urandom_range(1, 12);
        end
        // aim away from the segment to get behind-the-origin misses
        if ($urandom_range(0, 5) == 0) begin
            r.dx = -r.dx;
            r.dy = -r.dy;
        end
        return r;
    endfunction

    initial begin
        t_ray_seg r;
        int burst;

        // Directed table: typed rows read straight off the geometry.
        // all zero: degenerate, miss
        directed_rows.push_back(mk_typed('{default: '0}, 1'b0, '0, '0));
        // ray along +x through a vertical segment at x=5: hit at (5,0)
        directed_rows.push_back(mk_typed('{0, 0, ONE, 0, 5*ONE, -ONE, 5*ONE, ONE},
                                         1'b1, 5*ONE, 0));
        // same, unnormalized direction
        directed_rows.push_back(mk_typed('{0, 0, 7*ONE, 0, 5*ONE, -ONE, 5*ONE, ONE},
                                         1'b1, 5*ONE, 0));
        // hit exactly at segment start
        directed_rows.push_back(mk_typed('{0, 0, ONE, 0, 5*ONE, 0, 5*ONE, 2*ONE},
                                         1'b1, 5*ONE, 0));
        // hit exactly at segment end
        directed_rows.push_back(mk_typed('{0, 0, ONE, 0, 5*ONE, -2*ONE, 5*ONE, 0},
                                         1'b1, 5*ONE, 0));
        // origin on the segment: t = 0 counts
        directed_rows.push_back(mk_typed('{5*ONE, 0, ONE, 0, 5*ONE, -ONE, 5*ONE, ONE},
                                         1'b1, 5*ONE, 0));
        // segment behind the origin: miss
        directed_rows.push_back(mk_typed('{0, 0, -ONE, 0, 5*ONE, -ONE, 5*ONE, ONE},
                                         1'b0, '0, '0));
        // segment beside the ray line: miss
        directed_rows.push_back(mk_typed('{0, 0, ONE, 0, 5*ONE, ONE, 5*ONE, 3*ONE},
                                         1'b0, '0, '0));
        // parallel ray and segment: miss
        directed_rows.push_back(mk_typed('{0, 0, ONE, 0, ONE, ONE, 9*ONE, ONE},
                                         1'b0, '0, '0));
        // collinear: determinant zero, miss
        directed_rows.push_back(mk_typed('{0, 0, ONE, 0, ONE, 0, 9*ONE, 0},
                                         1'b0, '0, '0));
        // zero direction: miss
        directed_rows.push_back(mk_typed('{0, 0, 0, 0, 5*ONE, -ONE, 5*ONE, ONE},
                                         1'b0, '0, '0));
        // zero-length segment: miss
        directed_rows.push_back(mk_typed('{0, 0, ONE, 0, 5*ONE, 0, 5*ONE, 0},
                                         1'b0, '0, '0));
        // extremes, predicted
        directed_rows.push_back(mk('{C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX}));
        directed_rows.push_back(mk('{C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN}));
        directed_rows.push_back(mk('{C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX}));
        directed_rows.push_back(mk('{C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX}));
        directed_rows.push_back(mk('{0, 0, C_MAX, 1, C_MAX, C_MIN, C_MAX, C_MAX}));
        directed_rows.push_back(mk('{0, 0, C_MIN, -1, C_MIN, C_MIN, C_MIN, C_MAX}));
        directed_rows.push_back(mk('{C_MAX, C_MAX, 1, 1, C_MAX, C_MIN, C_MIN, C_MAX}));
        directed_rows.push_back(mk('{C_MIN, C_MIN, -1, -1, C_MIN, C_MAX, C_MAX, C_MIN}));
        // tiny direction, far segment: large t
        directed_rows.push_back(mk('{C_MIN, 0, 1, 0, C_MAX, -ONE, C_MAX, ONE}));
        directed_rows.push_back(mk('{-1, -1, 1, 1, 0, 1, 1, 0}));

        cur_row = mk('{default: '0});
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i], (i % 4 == 3) ? pick_gap() : 0);

        burst = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            // hold off until the pipe drains once, midway through
            if (n == N_RANDOM / 2) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (expected_points.size() != 0) @(posedge i_clk);
            end
            if (n % 100 == 0) burst = $urandom_range(0, 2);
            case ($urandom_range(0, 9))
                0, 1: r = '{rand_full(), rand_full(), rand_full(), rand_full(),
                            rand_full(), rand_full(), rand_full(), rand_full()};
                2: begin
                    // parallel or degenerate content
                    r = aimed_ray();
                    r.ex = r.sx + r.dx / 2;
                    r.ey = r.sy + r.dy / 2;
                end
                default: r = aimed_ray();
            endcase
            send_word(mk(r), (burst == 0) ? 0 : pick_gap());
        end
        start <= 1'b0;

        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Ran %0d words: %0d hits and %0d misses checked, directed edge cases first.",
                 n_words_in, n_hits_seen, n_miss_seen);
        if (n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
